@@ rtl/core/fvdsp_pkg.sv @@
// shared constants, types and codes for the four-voice delta sample player
package fvdsp_pkg;

  // sample memory geometry
  localparam int unsigned SLOTS      = 128;
  localparam int unsigned SLOT_BYTES = 4096;
  localparam int unsigned SLOT_AW    = $clog2(SLOT_BYTES);
  localparam int unsigned MEM_BYTES  = SLOTS * SLOT_BYTES;
  localparam int unsigned MEM_AW     = $clog2(MEM_BYTES);

  // field widths
  localparam int unsigned SLOT_W = 7;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned BYTE_W = 8;

  // voice count default
  localparam int unsigned DEF_VOICES = 4;

  // mix saturation and dac offset
  localparam int SAT_MAX = 127;
  localparam int SAT_MIN = -128;
  localparam logic [BYTE_W-1:0] DAC_OFFSET = 8'h80;

  // input beat codes
  typedef enum logic [1:0] {
    MODE_TICK      = 2'd0,
    MODE_PLAY      = 2'd1,
    MODE_LOAD_BYTE = 2'd2,
    MODE_LOAD_LEN  = 2'd3
  } mode_e;

  // sample memory write request
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } smem_wr_t;

  // length table write request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } len_wr_t;

endpackage

@@ rtl/core/fvdsp_if.sv @@
// input and output channel interfaces of the sample player

interface fvdsp_in_if;
  logic                          valid;
  logic                          ready;
  fvdsp_pkg::mode_e              mode;
  logic [fvdsp_pkg::SLOT_W-1:0]  sample_number;
  logic [fvdsp_pkg::MEM_AW-1:0]  byte_address;
  logic [fvdsp_pkg::BYTE_W-1:0]  byte_value;
  logic [fvdsp_pkg::LEN_W-1:0]   sample_length;

  modport source (
    output valid, mode, sample_number, byte_address, byte_value, sample_length,
    input  ready
  );
  modport sink (
    input  valid, mode, sample_number, byte_address, byte_value, sample_length,
    output ready
  );
endinterface

interface fvdsp_out_if;
  logic                          valid;
  logic                          ready;
  logic [fvdsp_pkg::BYTE_W-1:0]  dac_value;
  logic                          dac_changed;

  modport source (
    output valid, dac_value, dac_changed,
    input  ready
  );
  modport sink (
    input  valid, dac_value, dac_changed,
    output ready
  );
endinterface

@@ rtl/core/fvdsp_sample_ram.sv @@
// byte-wide sample memory, one write port and one registered read port
module fvdsp_sample_ram (
  input  logic                         clk_i,
  input  fvdsp_pkg::smem_wr_t          wr_i,
  input  logic                         rd_en_i,
  input  logic [fvdsp_pkg::MEM_AW-1:0] rd_addr_i,
  output logic [fvdsp_pkg::BYTE_W-1:0] rd_data_o
);
  import fvdsp_pkg::*;

  logic [BYTE_W-1:0] mem_q [MEM_BYTES];
  logic [BYTE_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/fvdsp_len_ram.sv @@
// per-slot length table with valid bits so that unwritten slots read zero
module fvdsp_len_ram (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fvdsp_pkg::len_wr_t           wr_i,
  input  logic                         rd_en_i,
  input  logic [fvdsp_pkg::SLOT_W-1:0] rd_slot_i,
  output logic [fvdsp_pkg::LEN_W-1:0]  rd_len_o
);
  import fvdsp_pkg::*;

  logic [LEN_W-1:0] mem_q [SLOTS];
  logic [SLOTS-1:0] vld_q;
  logic [LEN_W-1:0] rd_len_q;
  logic             rd_vld_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.slot] <= wr_i.len;
    end
    if (rd_en_i) begin
      rd_len_q <= mem_q[rd_slot_i];
    end
  end

  // valid bits and registered read valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.slot] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_slot_i];
      end
    end
  end

  // a slot never loaded has length zero
  assign rd_len_o = rd_vld_q ? rd_len_q : '0;

endmodule

@@ rtl/core/four_voice_delta_sample_player_core.sv @@
// Four-voice 1-bit delta sample player: loads, play starts and per-tick mixing.
// Load beats write when accepted; play beats read the length table, then start an idle voice.
// A tick holds the input off while it reads the sample memory once per voice, pipelined, and
// sums the updated voice levels, then saturates the mix into the output register.
// The result sits in an output register; a tick stalls only if it is still held.
// Reset clears voices, length valid bits, last dac value and control; sample memory is kept.
module four_voice_delta_sample_player_core #(
  parameter int unsigned VOICES = fvdsp_pkg::DEF_VOICES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fvdsp_in_if.sink     in_i,
  fvdsp_out_if.source  out_o
);
  import fvdsp_pkg::*;

  localparam int unsigned VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW    = $clog2(VOICES + 1);
  localparam int unsigned SUM_W = BYTE_W + $clog2(VOICES);

  typedef enum logic [1:0] {ST_IDLE, ST_PLAY, ST_TICK, ST_FIN} state_e;

  state_e                   state_q;
  logic [CW-1:0]            cnt_q;
  logic                     upd_q;
  logic [VW-1:0]            upd_idx_q;
  logic [SLOT_W-1:0]        slot_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [BYTE_W-1:0]        last_dac_q;
  logic                     out_valid_q;
  logic [BYTE_W-1:0]        out_dac_q;
  logic                     out_chg_q;

  logic [MEM_AW-1:0] addr_q [VOICES];
  logic [MEM_AW-1:0] end_q  [VOICES];
  logic [2:0]        bit_q  [VOICES];
  logic [BYTE_W-1:0] lvl_q  [VOICES];
  logic [VOICES-1:0] act_q;

  logic              in_fire;
  smem_wr_t          smem_wr;
  logic              smem_rd_en;
  logic [BYTE_W-1:0] smem_rdata;
  len_wr_t           len_wr;
  logic [LEN_W-1:0]  len_rd;
  logic              cnt_done;

  // handshake
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign cnt_done   = (cnt_q == CW'(VOICES));

  // memory requests; no accepts during a tick, so reads never meet a write
  assign smem_wr.en   = in_fire && (in_i.mode == MODE_LOAD_BYTE);
  assign smem_wr.addr = in_i.byte_address;
  assign smem_wr.data = in_i.byte_value;
  assign smem_rd_en   = (state_q == ST_TICK) && !cnt_done;

  assign len_wr.en   = in_fire && (in_i.mode == MODE_LOAD_LEN);
  assign len_wr.slot = in_i.sample_number;
  assign len_wr.len  = (in_i.sample_length > LEN_W'(SLOT_BYTES)) ? LEN_W'(SLOT_BYTES)
                                                                 : in_i.sample_length;

  fvdsp_sample_ram u_sample_ram (
    .clk_i     (clk_i),
    .wr_i      (smem_wr),
    .rd_en_i   (smem_rd_en),
    .rd_addr_i (addr_q[cnt_q[VW-1:0]]),
    .rd_data_o (smem_rdata)
  );

  fvdsp_len_ram u_len_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (len_wr),
    .rd_en_i   (in_fire && (in_i.mode == MODE_PLAY)),
    .rd_slot_i (in_i.sample_number),
    .rd_len_o  (len_rd)
  );

  // voice update from the byte just read
  logic [MEM_AW-1:0] upd_addr_step;
  logic [MEM_AW-1:0] upd_addr_n;
  logic [2:0]        upd_bit_n;
  logic [BYTE_W-1:0] upd_lvl_n;
  logic              upd_act_n;
  logic [2:0]        cur_bit;
  logic [BYTE_W-1:0] cur_lvl;

  always_comb begin
    cur_bit       = bit_q[upd_idx_q];
    cur_lvl       = lvl_q[upd_idx_q];
    upd_addr_step = addr_q[upd_idx_q];
    upd_addr_n    = addr_q[upd_idx_q];
    upd_bit_n     = cur_bit;
    upd_lvl_n     = cur_lvl;
    upd_act_n     = 1'b0;
    if (act_q[upd_idx_q]) begin
      upd_lvl_n = smem_rdata[cur_bit] ? cur_lvl + 1'b1 : cur_lvl - 1'b1;
      if (cur_bit == 3'd7) begin
        upd_addr_step = addr_q[upd_idx_q] + 1'b1;
      end
      if (upd_addr_step == end_q[upd_idx_q]) begin
        upd_addr_n = '0;
        upd_bit_n  = '0;
        upd_act_n  = 1'b0;
      end else begin
        upd_addr_n = upd_addr_step;
        upd_bit_n  = cur_bit + 3'd1;
        upd_act_n  = 1'b1;
      end
    end else if (cur_lvl[BYTE_W-1]) begin
      // idle voice ramps toward zero
      upd_lvl_n = cur_lvl + 1'b1;
    end else if (cur_lvl != '0) begin
      upd_lvl_n = cur_lvl - 1'b1;
    end
  end

  // lowest idle voice for a play start
  logic          free_found;
  logic [VW-1:0] free_idx;
  logic          play_go;
  logic [MEM_AW-1:0] play_base;
  logic [MEM_AW-1:0] play_end;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!act_q[v]) begin
        free_found = 1'b1;
        free_idx   = VW'(v);
      end
    end
  end

  assign play_go   = (state_q == ST_PLAY) && (len_rd != '0) && free_found;
  assign play_base = MEM_AW'(slot_q) << SLOT_AW;
  assign play_end  = play_base + MEM_AW'(len_rd);

  // voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      for (int v = 0; v < VOICES; v++) begin
        addr_q[v] <= '0;
        end_q[v]  <= '0;
        bit_q[v]  <= '0;
        lvl_q[v]  <= '0;
      end
    end else begin
      for (int v = 0; v < VOICES; v++) begin
        if (play_go && (free_idx == VW'(v))) begin
          addr_q[v] <= play_base;
          end_q[v]  <= play_end;
          bit_q[v]  <= '0;
          lvl_q[v]  <= '0;
          act_q[v]  <= 1'b1;
        end else if (upd_q && (upd_idx_q == VW'(v))) begin
          addr_q[v] <= upd_addr_n;
          bit_q[v]  <= upd_bit_n;
          lvl_q[v]  <= upd_lvl_n;
          act_q[v]  <= upd_act_n;
        end
      end
    end
  end

  // saturate the mix and shift to offset binary
  logic [BYTE_W-1:0] dac_d;

  always_comb begin
    if (sum_q > SAT_MAX) begin
      dac_d = BYTE_W'(SAT_MAX) ^ DAC_OFFSET;
    end else if (sum_q < SAT_MIN) begin
      dac_d = BYTE_W'(SAT_MIN) ^ DAC_OFFSET;
    end else begin
      dac_d = sum_q[BYTE_W-1:0] ^ DAC_OFFSET;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      upd_q       <= 1'b0;
      upd_idx_q   <= '0;
      slot_q      <= '0;
      sum_q       <= '0;
      last_dac_q  <= '0;
      out_valid_q <= 1'b0;
      out_dac_q   <= '0;
      out_chg_q   <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid_q && out_o.ready && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      if (upd_q) begin
        sum_q <= sum_q + SUM_W'($signed(upd_lvl_n));
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_i.mode)
              MODE_PLAY: begin
                slot_q  <= in_i.sample_number;
                state_q <= ST_PLAY;
              end
              MODE_TICK: begin
                cnt_q   <= '0;
                sum_q   <= '0;
                state_q <= ST_TICK;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_PLAY: begin
          state_q <= ST_IDLE;
        end
        ST_TICK: begin
          if (!cnt_done) begin
            upd_q     <= 1'b1;
            upd_idx_q <= cnt_q[VW-1:0];
            cnt_q     <= cnt_q + 1'b1;
          end else begin
            upd_q   <= 1'b0;
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_dac_q   <= dac_d;
            out_chg_q   <= (dac_d != last_dac_q);
            last_dac_q  <= dac_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.dac_value   = out_dac_q;
  assign out_o.dac_changed = out_chg_q;

endmodule
